FILE: sv/segment_count_and_index_mapper_macros.svh
// Assertion shorthands for the segment mapper. Each use sits on a line of its own.
`ifndef SEGMENT_COUNT_AND_INDEX_MAPPER_MACROS_SVH
`define SEGMENT_COUNT_AND_INDEX_MAPPER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SCIM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("scim: assertion failed");

// A condition that, once seen, must be followed by another one in the next cycle.
`define SCIM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scim: assertion failed");

`endif

FILE: sv/scim_pkg.sv
package scim_pkg;

  localparam int MaxBootstrap = 16;

  localparam int KindW   = 2;
  localparam int EntryW  = 4;
  localparam int ValueW  = 64;
  localparam int ResultW = 32;
  localparam int StatusW = 2;
  localparam int ModeW   = 2;
  localparam int DurW    = 32;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  // Item kinds.
  localparam logic [KindW-1:0] KindLoad  = 2'd0;
  localparam logic [KindW-1:0] KindCount = 2'd1;
  localparam logic [KindW-1:0] KindIndex = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StInvalid  = 2'd1;
  localparam logic [StatusW-1:0] StBadEntry = 2'd2;

  // Count rounding modes; the unused code behaves as ceiling.
  localparam logic [ModeW-1:0] ModeCeil  = 2'd0;
  localparam logic [ModeW-1:0] ModeFloor = 2'd1;
  localparam logic [ModeW-1:0] ModeRound = 2'd2;

  // Register indexes, taken from the word address.
  localparam logic RegSegDur    = 1'b0;
  localparam logic RegCountMode = 1'b1;

  localparam logic [DurW-1:0]  SegDurReset = 32'd10000;
  localparam logic [ModeW-1:0] ModeReset   = ModeCeil;

  // Largest regular count headroom: 2^32 - 1 - 2, less the table length.
  localparam logic [DurW-1:0] OvfBase = 32'hFFFF_FFFD;

endpackage

FILE: sv/scim_if.sv
interface scim_req_if;
  logic                             valid;
  logic                             ready;
  logic [scim_pkg::KindW-1:0]       kind;
  logic [scim_pkg::EntryW-1:0]      entry_index;
  logic [scim_pkg::ValueW-1:0]      value;

  modport source (output valid, output kind, output entry_index, output value, input ready);
  modport sink   (input valid, input kind, input entry_index, input value, output ready);
endinterface

interface scim_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [scim_pkg::ResultW-1:0]     result;
  logic [scim_pkg::StatusW-1:0]     status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

FILE: sv/scim_ram.sv
module scim_ram #(
  parameter int Width = 64,
  parameter int Depth = scim_pkg::MaxBootstrap,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/scim_div.sv
module scim_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [scim_pkg::ValueW-1:0] dividend_i,
  input  logic [scim_pkg::DurW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [scim_pkg::ValueW-1:0] quotient_o,
  output logic                        rem_nz_o
);

  localparam int DivW  = scim_pkg::ValueW;
  localparam int DsrW  = scim_pkg::DurW;
  localparam int StepW = $clog2(DivW);
  localparam logic [StepW-1:0] LastStep = StepW'(DivW - 1);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [DivW-1:0]  quo_q;
  logic [DsrW-1:0]  rem_q;
  logic [DsrW-1:0]  dsr_q;
  logic [DsrW:0]    shifted;
  logic             fits;
  logic [DsrW-1:0]  rem_next;

  // Restoring division, one quotient bit per cycle, most significant first.
  always_comb begin
    shifted  = {rem_q, quo_q[DivW-1]};
    fits     = shifted >= {1'b0, dsr_q};
    rem_next = fits ? DsrW'(shifted - {1'b0, dsr_q}) : shifted[DsrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], fits};
      rem_q <= rem_next;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign rem_nz_o   = rem_q != '0;

endmodule

FILE: sv/segment_count_and_index_mapper.sv
// A load passes the prepare and load states, a table lookup walks the loaded entries in
// turn, and some counts and indexes use the 64-step serial divider. One item is worked on
// at a time; the next input is taken once the result has moved to the output register, so
// the block cannot take a new item before the last one is through. Reset (asynchronous,
// low) empties the table, clears the total and restores the register defaults.
module segment_count_and_index_mapper #(
  parameter int MaxBootstrap = scim_pkg::MaxBootstrap
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  scim_req_if.sink                      req_i,
  scim_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scim_pkg::ApbAddrW-1:0] paddr,
  input  logic [scim_pkg::ApbDataW-1:0] pwdata,
  output logic [scim_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  localparam int AddrW = (MaxBootstrap > 1) ? $clog2(MaxBootstrap) : 1;
  localparam int CntW  = $clog2(MaxBootstrap + 1);
  localparam int DurW  = scim_pkg::DurW;
  localparam int ValW  = scim_pkg::ValueW;
  localparam int EntW  = 2 * DurW;

  typedef enum logic [6:0] {
    SIdle   = 7'b0000001,
    SPrep   = 7'b0000010,
    SLoad   = 7'b0000100,
    SCheck  = 7'b0001000,
    SDiv    = 7'b0010000,
    SWalk   = 7'b0100000,
    SFinish = 7'b1000000
  } state_e;

  state_e                          state_q, state_d;
  logic [scim_pkg::KindW-1:0]      kind_q;
  logic [scim_pkg::EntryW-1:0]     idx_q;
  logic [ValW-1:0]                 val_q;
  logic [ValW-1:0]                 work_q, work_d;
  logic [ValW-1:0]                 prod_q, prod_d;
  logic [CntW-1:0]                 walk_q, walk_d;
  logic [DurW-1:0]                 prev_end_q, prev_end_d;
  logic [scim_pkg::ResultW-1:0]    res_q, res_d;
  logic [scim_pkg::StatusW-1:0]    st_q, st_d;
  logic [CntW-1:0]                 bc_q, bc_d;
  logic [DurW-1:0]                 total_q, total_d;
  logic [DurW-1:0]                 sd_q;
  logic [scim_pkg::ModeW-1:0]      mode_q;
  logic                            out_valid_q;
  logic [scim_pkg::ResultW-1:0]    out_res_q;
  logic [scim_pkg::StatusW-1:0]    out_st_q;

  logic                            ram_we;
  logic [AddrW-1:0]                ram_raddr;
  logic [EntW-1:0]                 ram_wdata;
  logic [EntW-1:0]                 ram_rdata;
  logic [DurW-1:0]                 rd_dur;
  logic [DurW-1:0]                 rd_end;

  logic                            div_start;
  logic [ValW-1:0]                 div_dividend;
  logic                            div_done;
  logic [ValW-1:0]                 div_quo;
  logic                            div_rem_nz;

  logic                            is_ceil;
  logic                            is_floor;
  logic                            is_round;
  logic                            in_accept;
  logic                            out_take;
  logic                            cfg_wr;
  logic                            ld_bad;
  logic                            cnt_regular;
  logic [DurW-1:0]                 ovf_k;
  logic [DurW-1:0]                 ld_start;
  logic [DurW:0]                   ld_end;
  logic [ValW:0]                   sum;
  logic [ValW:0]                   th;
  logic                            walk_pass;
  logic                            walk_last;

  assign is_floor  = mode_q == scim_pkg::ModeFloor;
  assign is_round  = mode_q == scim_pkg::ModeRound;
  assign is_ceil   = !is_floor && !is_round;
  assign in_accept = req_i.valid && req_i.ready;
  assign out_take  = out_valid_q && rsp_o.ready;
  assign rd_dur    = ram_rdata[EntW-1:DurW];
  assign rd_end    = ram_rdata[DurW-1:0];

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == scim_pkg::RegCountMode) ?
                  {{(scim_pkg::ApbDataW - scim_pkg::ModeW){1'b0}}, mode_q} : sd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_q   <= scim_pkg::SegDurReset;
      mode_q <= scim_pkg::ModeReset;
    end else if (cfg_wr) begin
      if (paddr[2] == scim_pkg::RegSegDur) begin
        sd_q <= pwdata;
      end else begin
        mode_q <= pwdata[scim_pkg::ModeW-1:0];
      end
    end
  end

  // Both per-entry values share one memory word: duration above, end offset below.
  scim_ram #(
    .Width (EntW),
    .Depth (MaxBootstrap)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(idx_q)),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  scim_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (sd_q),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .rem_nz_o   (div_rem_nz)
  );

  always_comb begin
    ld_bad = (32'(idx_q) >= 32'(MaxBootstrap)) || (32'(idx_q) > 32'(bc_q)) ||
             (val_q == '0) || (val_q[ValW-1:DurW] != '0);
    cnt_regular = is_ceil ? (val_q > ValW'(total_q)) : (val_q >= ValW'(total_q));
    ovf_k       = scim_pkg::OvfBase - DurW'(bc_q);
    ld_start    = (idx_q == '0) ? '0 : rd_end;
    ld_end      = {1'b0, ld_start} + {1'b0, val_q[DurW-1:0]};
    ram_wdata   = {val_q[DurW-1:0], ld_end[DurW-1:0]};
    th          = is_floor ? (ValW+1)'(rd_end)
                           : (ValW+1)'(prev_end_q) + (ValW+1)'(rd_dur >> 1);
    walk_last   = (32'(walk_q) + 32'd1) >= 32'(bc_q);
    sum         = (ValW+1)'(bc_q) + {1'b0, div_quo} +
                  (ValW+1)'((kind_q == scim_pkg::KindCount) && is_ceil && div_rem_nz);

    // The first count step only primes the previous end offset.
    if (kind_q == scim_pkg::KindIndex) begin
      walk_pass = val_q >= ValW'(rd_end);
    end else if (walk_q == '0) begin
      walk_pass = 1'b1;
    end else if (is_ceil) begin
      walk_pass = val_q > ValW'(prev_end_q);
    end else begin
      walk_pass = {1'b0, val_q} >= th;
    end
  end

  always_comb begin
    state_d      = state_q;
    work_d       = work_q;
    prod_d       = prod_q;
    walk_d       = walk_q;
    prev_end_d   = prev_end_q;
    res_d        = res_q;
    st_d         = st_q;
    bc_d         = bc_q;
    total_d      = total_q;
    ram_we       = 1'b0;
    ram_raddr    = '0;
    div_start    = 1'b0;
    div_dividend = work_q;

    case (state_q)
      SIdle: begin
        if (req_i.valid) begin
          state_d = SPrep;
        end
      end
      SPrep: begin
        res_d  = '0;
        st_d   = scim_pkg::StOk;
        walk_d = '0;
        case (kind_q)
          scim_pkg::KindLoad: begin
            ram_raddr = AddrW'(32'(idx_q) - 32'd1);
            if (ld_bad) begin
              st_d    = scim_pkg::StBadEntry;
              state_d = SFinish;
            end else begin
              state_d = SLoad;
            end
          end
          scim_pkg::KindCount: begin
            if (val_q == '0) begin
              state_d = SFinish;
            end else if (cnt_regular) begin
              work_d  = val_q - ValW'(total_q);
              prod_d  = sd_q * ovf_k;
              state_d = SCheck;
            end else begin
              state_d = SWalk;
            end
          end
          scim_pkg::KindIndex: begin
            if (val_q >= ValW'(total_q)) begin
              if (sd_q == '0) begin
                st_d    = scim_pkg::StInvalid;
                state_d = SFinish;
              end else begin
                div_start    = 1'b1;
                div_dividend = val_q - ValW'(total_q);
                state_d      = SDiv;
              end
            end else begin
              state_d = SWalk;
            end
          end
          default: begin
            state_d = SFinish;
          end
        endcase
      end
      SLoad: begin
        if (ld_end[DurW]) begin
          st_d = scim_pkg::StBadEntry;
        end else begin
          ram_we  = 1'b1;
          bc_d    = CntW'(32'(idx_q) + 32'd1);
          total_d = ld_end[DurW-1:0];
        end
        state_d = SFinish;
      end
      SCheck: begin
        if ((work_q > prod_q) || (sd_q == '0)) begin
          st_d    = scim_pkg::StInvalid;
          state_d = SFinish;
        end else begin
          div_start    = 1'b1;
          div_dividend = is_round ? work_q + ValW'(sd_q >> 1) : work_q;
          state_d      = SDiv;
        end
      end
      SDiv: begin
        if (div_done) begin
          if ((kind_q == scim_pkg::KindCount) && (sum == '0)) begin
            res_d = 32'd1;
          end else if (sum[ValW:scim_pkg::ResultW] != '0) begin
            st_d = scim_pkg::StInvalid;
          end else begin
            res_d = sum[scim_pkg::ResultW-1:0];
          end
          state_d = SFinish;
        end
      end
      SWalk: begin
        // The memory output holds entry walk_q; the next entry is read meanwhile.
        ram_raddr = AddrW'(32'(walk_q) + 32'd1);
        if (!walk_pass) begin
          res_d   = 32'(walk_q);
          state_d = SFinish;
        end else if (walk_last) begin
          res_d   = 32'(walk_q) + 32'd1;
          state_d = SFinish;
        end else begin
          walk_d     = walk_q + 1'b1;
          prev_end_d = rd_end;
        end
      end
      SFinish: begin
        if (!out_valid_q || rsp_o.ready) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      bc_q        <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bc_q    <= bc_d;
      total_q <= total_d;
      if ((state_q == SFinish) && (!out_valid_q || rsp_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= req_i.kind;
      idx_q  <= req_i.entry_index;
      val_q  <= req_i.value;
    end
    work_q     <= work_d;
    prod_q     <= prod_d;
    walk_q     <= walk_d;
    prev_end_q <= prev_end_d;
    res_q      <= res_d;
    st_q       <= st_d;
    if ((state_q == SFinish) && (!out_valid_q || rsp_o.ready)) begin
      out_res_q <= res_q;
      out_st_q  <= st_q;
    end
  end

  assign req_i.ready  = state_q == SIdle;
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.result = out_res_q;
  assign rsp_o.status = out_st_q;

`include "segment_count_and_index_mapper_macros.svh"

  `SCIM_ASSERT(a_table_write_in_load, ram_we |-> (state_q == SLoad))
  `SCIM_ASSERT(a_div_done_in_div, div_done |-> (state_q == SDiv))
  `SCIM_ASSERT(a_count_bounded, 32'(bc_q) <= 32'(MaxBootstrap))
  `SCIM_ASSERT_NEXT(a_busy_after_accept, in_accept, !req_i.ready)

endmodule

FILE: dv/tb_segment_count_and_index_mapper.sv
module tb_segment_count_and_index_mapper;
  timeunit 1ns;
  timeprecision 1ps;

  import scim_pkg::*;

  localparam logic [KindW-1:0] KindSpare = 2'd3;
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;
  localparam logic [63:0]      U32Max    = 64'hFFFF_FFFF;
  localparam int unsigned      RandItems = 1100;
  localparam int unsigned      MaxWait   = 13;
  localparam int unsigned      HoldCycles = 500;

  typedef struct {
    logic [KindW-1:0]  kind;
    logic [EntryW-1:0] idx;
    logic [ValueW-1:0] val;
    int unsigned       gap;
  } seg_req_t;

  typedef struct packed {
    logic [ResultW-1:0] result;
    logic [StatusW-1:0] status;
  } seg_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  scim_req_if req_if ();
  scim_rsp_if rsp_if ();

  segment_count_and_index_mapper u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted block state: bootstrap table and register copies.
  logic [DurW-1:0]  tbl_dur [MaxBootstrap];
  logic [DurW-1:0]  tbl_end [MaxBootstrap];
  int unsigned      tbl_len;
  logic [DurW-1:0]  tbl_total;
  logic [DurW-1:0]  cfg_seg_dur;
  logic [ModeW-1:0] cfg_mode;

  // Table as the stimulus generator expects it, used to aim values at boundaries.
  logic [63:0] plan_end [MaxBootstrap];
  int unsigned plan_len;

  seg_req_t    req_q[$];
  seg_result_t seg_result_q[$];
  int unsigned src_wait;
  int unsigned snk_wait;
  int unsigned item_cnt;
  int unsigned err_cnt;
  bit          src_idle;
  bit          sink_idle;
  bit          sink_hold;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("tb_segment_count_and_index_mapper: errors");
    $finish;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic seg_result_t map_item(input seg_req_t it);
    seg_result_t      r;
    logic [ModeW-1:0] mode;
    logic [63:0]      sd;
    logic [63:0]      d;
    logic [63:0]      s;
    logic [63:0]      q;
    logic [63:0]      cnt;
    logic [63:0]      thr;
    int unsigned      i;
    bit               stop;
    r.result = '0;
    r.status = StOk;
    mode = (cfg_mode == ModeSpare) ? ModeCeil : cfg_mode;
    sd = {32'd0, cfg_seg_dur};
    case (it.kind)
      KindLoad: begin
        s = (it.idx == 0) ? 64'd0 : {32'd0, tbl_end[it.idx - 1]};
        if (it.idx > tbl_len || it.val == 0 || it.val > U32Max || s + it.val > U32Max) begin
          r.status = StBadEntry;
        end else begin
          d = s + it.val;
          tbl_dur[it.idx] = it.val[31:0];
          tbl_end[it.idx] = d[31:0];
          tbl_len = it.idx + 1;
          tbl_total = d[31:0];
        end
      end
      KindCount: begin
        d = it.val;
        if (d != 0) begin
          if ((mode == ModeCeil) ? (d > tbl_total) : (d >= tbl_total)) begin
            d = d - tbl_total;
            if (d > sd * (U32Max - tbl_len - 2) || sd == 0) begin
              r.status = StInvalid;
            end else begin
              case (mode)
                ModeCeil:  q = d / sd + ((d % sd) != 0 ? 64'd1 : 64'd0);
                ModeFloor: q = d / sd;
                default:   q = (d + sd / 2) / sd;
              endcase
              cnt = tbl_len + q;
              if (cnt == 0) cnt = 1;
              if (cnt > U32Max) r.status = StInvalid;
              else r.result = cnt[31:0];
            end
          end else begin
            // Walk the table until the segment that holds the end of the duration.
            i = 1;
            stop = 1'b0;
            while (i < tbl_len && !stop) begin
              s = {32'd0, tbl_end[i - 1]};
              if (mode == ModeCeil) begin
                stop = !(d > s);
              end else begin
                thr = (mode == ModeFloor) ? {32'd0, tbl_end[i]} : s + tbl_dur[i] / 2;
                stop = !(d >= thr);
              end
              if (!stop) i++;
            end
            r.result = i;
          end
        end
      end
      KindIndex: begin
        if (it.val >= tbl_total) begin
          if (sd == 0) begin
            r.status = StInvalid;
          end else begin
            cnt = tbl_len + (it.val - tbl_total) / sd;
            if (cnt > U32Max) r.status = StInvalid;
            else r.result = cnt[31:0];
          end
        end else begin
          i = 0;
          while (i < tbl_len && !(it.val < tbl_end[i])) i++;
          r.result = i;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    seg_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        seg_result_q.push_back(map_item('{kind: req_if.kind, idx: req_if.entry_index,
                                          val: req_if.value, gap: 0}));
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_q.size() != 0 && src_wait >= req_q[0].gap) begin
          nxt = req_q.pop_front();
          req_if.valid       <= 1'b1;
          req_if.kind        <= nxt.kind;
          req_if.entry_index <= nxt.idx;
          req_if.value       <= nxt.val;
          src_wait <= 0;
        end else begin
          req_if.valid <= 1'b0;
          if (req_q.size() != 0) src_wait <= src_wait + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    seg_result_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (seg_result_q.size() == 0) begin
          report("unexpected transaction", {rsp_if.result, rsp_if.status}, '0);
        end else begin
          want = seg_result_q.pop_front();
          if (rsp_if.result !== want.result) report("result", rsp_if.result, want.result);
          if (rsp_if.status !== want.status) report("status", rsp_if.status, want.status);
        end
        snk_wait = sink_idle ? $urandom_range(0, MaxWait) : 0;
      end else if (snk_wait != 0 && !sink_hold) begin
        snk_wait--;
      end
      rsp_if.ready <= !sink_hold && snk_wait == 0;
    end
  end

  function automatic void plan_load(input logic [EntryW-1:0] idx, input logic [63:0] v);
    logic [63:0] s;
    s = (idx == 0) ? 64'd0 : plan_end[idx - 1];
    if (idx <= plan_len && v != 0 && v <= U32Max && s + v <= U32Max) begin
      plan_end[idx] = s + v;
      plan_len = idx + 1;
    end
  endfunction

  task automatic push_item(input logic [KindW-1:0] kind, input logic [EntryW-1:0] idx,
                           input logic [ValueW-1:0] val);
    req_q.push_back('{kind: kind, idx: idx, val: val,
                      gap: src_idle ? $urandom_range(0, MaxWait) : 0});
    if (kind == KindLoad) plan_load(idx, val);
    item_cnt++;
  endtask

  function automatic logic [ValueW-1:0] pick_dur();
    case ($urandom_range(0, 11))
      0:       return {32'd0, $urandom};
      1:       return 64'd1;
      2:       return $urandom_range(1, 3);
      default: return $urandom_range(1, 20000);
    endcase
  endfunction

  // Mostly times near table edges, segment midpoints and the overflow limits.
  function automatic logic [ValueW-1:0] pick_value();
    logic [63:0] tot;
    logic [63:0] sd;
    logic [63:0] s;
    int unsigned k;
    tot = (plan_len == 0) ? 64'd0 : plan_end[plan_len - 1];
    sd = {32'd0, cfg_seg_dur};
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        if (plan_len == 0) return $urandom_range(0, 3);
        k = $urandom_range(0, plan_len - 1);
        s = (k == 0) ? 64'd0 : plan_end[k - 1];
        if ($urandom_range(0, 1) != 0) return plan_end[k] + $urandom_range(0, 2) - 1;
        return s + (plan_end[k] - s) / 2 + $urandom_range(0, 2) - 1;
      end
      3, 4: begin
        s = tot + sd * $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) return s + sd / 2;
        return s + $urandom_range(0, 2) - 1;
      end
      5:       return {$urandom, $urandom};
      6:       return $urandom_range(0, 100000);
      7:       return tot + sd * (64'hFFFF_FFFD - plan_len) + $urandom_range(0, 1);
      8:       return tot + sd * (64'h1_0000_0000 - plan_len) + $urandom_range(0, 1) - 1;
      9:       return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
      10:      return $urandom;
      default: return 64'd0;
    endcase
  endfunction

  task automatic set_reg(input logic sel, input logic [ApbDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == RegSegDur) cfg_seg_dur = data;
    else cfg_mode = data[ModeW-1:0];
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (req_q.size() != 0 || req_if.valid || seg_result_q.size() != 0);
  endtask

  initial begin
    int unsigned      phase;
    int unsigned      n;
    logic [DurW-1:0]  sd;
    req_if.valid       = 1'b0;
    req_if.kind        = KindLoad;
    req_if.entry_index = '0;
    req_if.value       = '0;
    rsp_if.ready       = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    tbl_len     = 0;
    tbl_total   = '0;
    cfg_seg_dur = SegDurReset;
    cfg_mode    = ModeReset;
    plan_len  = 0;
    item_cnt  = 0;
    err_cnt   = 0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    sink_hold = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table with the reset register values.
    push_item(KindIndex, 4'd0, 64'd0);
    push_item(KindIndex, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(KindCount, 4'd0, 64'd0);
    push_item(KindCount, 4'd0, 64'd1);
    push_item(KindCount, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    // Loads: gap, zero, too wide, two good entries, end past 32 bits, last slot out of order.
    push_item(KindLoad, 4'd1, 64'd100);
    push_item(KindLoad, 4'd0, 64'd0);
    push_item(KindLoad, 4'd0, 64'h1_0000_0000);
    push_item(KindLoad, 4'd0, 64'd5000);
    push_item(KindLoad, 4'd1, 64'd3000);
    push_item(KindLoad, 4'd2, 64'hFFFF_FFFF);
    push_item(KindLoad, 4'd15, 64'd7);
    // Rewriting the last entry changes the table total.
    push_item(KindLoad, 4'd1, 64'd4000);
    push_item(KindCount, 4'd0, 64'd5000);
    push_item(KindCount, 4'd0, 64'd5001);
    push_item(KindCount, 4'd0, 64'd9000);
    push_item(KindCount, 4'd0, 64'd9001);
    push_item(KindIndex, 4'd0, 64'd4999);
    push_item(KindIndex, 4'd0, 64'd5000);
    push_item(KindIndex, 4'd0, 64'd29000);
    push_item(KindSpare, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle();
    set_reg(RegCountMode, {30'd0, ModeFloor});
    set_reg(RegSegDur, 32'd1);
    push_item(KindCount, 4'd0, 64'd8999);
    push_item(KindCount, 4'd0, 64'd9000);
    wait_idle();
    set_reg(RegCountMode, {30'd0, ModeRound});
    set_reg(RegSegDur, 32'hFFFF_FFFF);
    push_item(KindCount, 4'd0, 64'd7000);
    push_item(KindIndex, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle();
    set_reg(RegCountMode, {30'd0, ModeSpare});
    set_reg(RegSegDur, 32'd0);
    push_item(KindCount, 4'd0, 64'd9001);
    push_item(KindIndex, 4'd0, 64'd9000);
    push_item(KindIndex, 4'd0, 64'd10);

    item_cnt = 0;
    phase = 0;
    while (item_cnt < RandItems) begin
      // The sender stops here until every result of the last phase is in.
      wait_idle();
      case (phase)
        0: sd = 32'd1;
        1: sd = 32'hFFFF_FFFF;
        2: sd = 32'd0;
        default: begin
          case ($urandom_range(0, 5))
            0:       sd = $urandom;
            1, 2:    sd = $urandom_range(1, 50);
            default: sd = $urandom_range(1000, 20000);
          endcase
        end
      endcase
      set_reg(RegSegDur, sd);
      set_reg(RegCountMode, ($urandom & 32'hFFFF_FFFC) | (phase % 4));
      src_idle  = $urandom_range(0, 2) != 0;
      sink_idle = $urandom_range(0, 2) != 0;
      if (phase == 4) begin
        fork
          begin
            sink_hold = 1'b1;
            repeat (HoldCycles) @(negedge clk_i);
            sink_hold = 1'b0;
          end
        join_none
      end
      repeat (4) begin
        n = ($urandom_range(0, 3) == 0) ? MaxBootstrap : $urandom_range(0, MaxBootstrap - 1);
        for (int j = 0; j < n; j++) push_item(KindLoad, EntryW'(j), pick_dur());
        if (n > 1 && $urandom_range(0, 3) == 0)
          push_item(KindLoad, $urandom_range(0, n - 1), pick_dur());
        repeat ($urandom_range(8, 20)) begin
          if ($urandom_range(0, 7) == 0) begin
            push_item($urandom_range(0, 3), $urandom_range(0, 15),
                      ($urandom_range(0, 1) != 0) ? {$urandom, $urandom}
                                                   : 64'($urandom_range(0, 30000)));
          end else begin
            push_item(($urandom_range(0, 1) != 0) ? KindCount : KindIndex,
                      $urandom_range(0, 15), pick_value());
          end
        end
      end
      phase++;
    end

    wait_idle();
    repeat (100) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_segment_count_and_index_mapper: clean");
    end else begin
      $display("tb_segment_count_and_index_mapper: errors");
    end
    $finish;
  end

endmodule
